FILE: rtl/core/se2_pkg.sv
package se2_pkg;

  // default CORDIC depth
  localparam int CORDIC_ITER_DEF = 24;

  // angle constants, Q4.28, sized for the wrap arithmetic
  localparam logic signed [34:0] PI_Q      = 35'sd843314857;
  localparam logic signed [34:0] TWO_PI_Q  = 35'sd1686629713;
  localparam logic signed [34:0] HALF_PI_Q = 35'sd421657428;

  // Q2.30 one and CORDIC start vector
  localparam logic signed [34:0] ONE_Q30  = 35'sd1073741824;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  // increment clamp, Q16.16
  localparam logic [69:0] INC_LIMIT = 70'd4294967296;

  // threshold reset value
  localparam logic [15:0] THR_RESET = 16'd1;

  // one queued twist, already classified
  typedef struct packed {
    logic               restart;
    logic               is_small;
    logic signed [31:0] omega;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } se2_item_t;

  // back-end sequencer
  typedef enum logic [2:0] {
    B_IDLE,
    B_CORD,
    B_NUM,
    B_DIV,
    B_ROT,
    B_OUT
  } se2_bstate_t;

  // wrap an angle into [-pi, pi)
  function automatic logic signed [34:0] wrap_angle(input logic signed [34:0] a);
    logic signed [34:0] v;
    v = a;
    for (int k = 0; k < 4; k++) begin
      if (v >= PI_Q) v = v - TWO_PI_Q;
    end
    for (int k = 0; k < 4; k++) begin
      if (v < -PI_Q) v = v + TWO_PI_Q;
    end
    return v;
  endfunction

  // atan(2^-i), Q2.30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/se2_cordic.sv
module se2_cordic #(
  parameter int ITER = se2_pkg::CORDIC_ITER_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [31:0]  angle,
  output logic                busy,
  output logic signed [33:0]  sin_o,
  output logic signed [33:0]  cos_o
);
  import se2_pkg::*;

  localparam int CW = $clog2(ITER + 1);

  logic               busy_r;
  logic [CW-1:0]      cnt_r;
  logic signed [33:0] x_r, y_r;
  logic signed [34:0] z_r;
  logic               neg_r;

  logic signed [34:0] a_w, a_f, at;
  logic               fold;
  logic signed [33:0] dx, dy;
  logic [5:0]         idx6;

  // wrap and fold the start angle into [-pi/2, pi/2]
  always_comb begin
    a_w  = wrap_angle(35'(angle));
    a_f  = a_w;
    fold = 1'b0;
    if (a_w > HALF_PI_Q) begin
      a_f  = a_w - PI_Q;
      fold = 1'b1;
    end else if (a_w < -HALF_PI_Q) begin
      a_f  = a_w + PI_Q;
      fold = 1'b1;
    end
  end

  // one micro-rotation
  assign idx6 = 6'(cnt_r);
  assign at   = $signed({5'd0, atan_q30(idx6[4:0])});
  assign dx   = y_r >>> cnt_r;
  assign dy   = x_r >>> cnt_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(ITER - 1)) busy_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= GAIN_Q30;
      y_r   <= '0;
      z_r   <= a_f <<< 2;
      neg_r <= fold;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign busy  = busy_r;
  assign sin_o = neg_r ? -y_r : y_r;
  assign cos_o = neg_r ? -x_r : x_r;

endmodule

FILE: rtl/core/se2_div.sv
module se2_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [69:0]  num,
  input  logic signed [33:0]  den,
  output logic                busy,
  output logic signed [33:0]  quo
);
  import se2_pkg::*;

  logic        busy_r;
  logic [6:0]  cnt_r;
  logic [34:0] rem_r;
  logic [69:0] q_r;
  logic [33:0] d_r;
  logic        neg_r;

  logic [34:0] sh;
  logic        ge;
  logic [33:0] mag;

  // restoring step, one quotient bit per cycle
  assign sh = {rem_r[33:0], q_r[69]};
  assign ge = sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == 7'd69) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[69] ? 70'(-num) : 70'(num);
      d_r   <= den[33] ? 34'(-den) : 34'(den);
      rem_r <= '0;
      neg_r <= num[69] ^ den[33];
    end else if (busy_r) begin
      rem_r <= ge ? sh - {1'b0, d_r} : sh;
      q_r   <= {q_r[68:0], ge};
    end
  end

  // truncated quotient, clamped to the increment limit
  assign mag  = (q_r > INC_LIMIT) ? INC_LIMIT[33:0] : q_r[33:0];
  assign quo  = neg_r ? -$signed(mag) : $signed(mag);
  assign busy = busy_r;

endmodule

FILE: rtl/core/se2_front.sv
module se2_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                push,
  output logic                full,
  input  logic                restart,
  input  logic signed [31:0]  omega,
  input  logic signed [31:0]  vel_x,
  input  logic signed [31:0]  vel_y,
  output logic                q_valid,
  output se2_pkg::se2_item_t  q_item,
  input  logic                q_pop
);
  import se2_pkg::*;

  logic [15:0] thr_r;
  se2_item_t   fifo_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  logic [32:0] aw;
  se2_item_t   cls;
  logic        do_push;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n)      thr_r <= THR_RESET;
    else if (cfg_we) thr_r <= cfg_data;
  end

  // classify: small or zero rotation is a pure translation
  always_comb begin
    aw           = omega[31] ? 33'(-$signed(33'(omega))) : 33'(omega);
    cls.restart  = restart;
    cls.is_small = (omega == 0) || (aw < 33'(thr_r));
    cls.omega    = omega;
    cls.vel_x    = vel_x;
    cls.vel_y    = vel_y;
  end

  assign full    = cnt_r == 2'd2;
  assign do_push = push && !full;
  assign q_valid = cnt_r != 2'd0;
  assign q_item  = fifo_r[rp_r];

  // two-entry queue to the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (q_pop)   rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) fifo_r[wp_r] <= cls;
  end

endmodule

FILE: rtl/core/se2_back.sv
module se2_back #(
  parameter int ITER = se2_pkg::CORDIC_ITER_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  se2_pkg::se2_item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                pop,
  output logic signed [31:0]  pose_x,
  output logic signed [31:0]  pose_y,
  output logic signed [31:0]  heading,
  output logic                saturated
);
  import se2_pkg::*;

  se2_bstate_t st_r, st_nxt;
  se2_item_t   item_r;
  logic [2:0]  step_r;
  logic        out_valid_r;

  logic signed [31:0] pos_x_r, pos_y_r, head_r;
  logic signed [68:0] prod_r;
  logic signed [69:0] nacc_x_r, nacc_y_r;
  logic signed [33:0] tx_r, ty_r;
  logic signed [39:0] accx_r, accy_r;
  logic signed [31:0] ox_r, oy_r, oh_r;
  logic               osat_r;

  logic               start_h, start_w, busy_h, busy_w;
  logic signed [33:0] sh, ch, sw, cw;
  logic               div_start, busy_dx, busy_dy;
  logic signed [33:0] qx, qy;
  logic signed [69:0] num_y;
  logic signed [33:0] ma;
  logic signed [34:0] mb;
  logic signed [68:0] pr;
  logic signed [38:0] rnd;
  logic signed [31:0] sx, sy;
  logic               hx, hy;
  logic signed [34:0] hsum;

  // sin/cos of the heading, and of the twist angle unless the twist is small, run side by side
  assign start_h = (st_r == B_IDLE) && q_valid;
  assign start_w = start_h && !q_item.is_small;

  se2_cordic #(.ITER(ITER)) u_cord_w (
    .clk(clk), .rst_n(rst_n), .start(start_w), .angle(q_item.omega),
    .busy(busy_w), .sin_o(sw), .cos_o(cw)
  );

  se2_cordic #(.ITER(ITER)) u_cord_h (
    .clk(clk), .rst_n(rst_n), .start(start_h),
    .angle(q_item.restart ? 32'sd0 : head_r),
    .busy(busy_h), .sin_o(sh), .cos_o(ch)
  );

  // the two quotients, n / (4 w)
  assign div_start = (st_r == B_NUM) && (step_r == 3'd4);
  assign num_y     = nacc_y_r + 70'(prod_r);

  se2_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(nacc_x_r),
    .den({item_r.omega, 2'b00}), .busy(busy_dx), .quo(qx)
  );

  se2_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_y),
    .den({item_r.omega, 2'b00}), .busy(busy_dy), .quo(qy)
  );

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    if (st_r == B_NUM) begin
      case (step_r)
        3'd0: begin ma = 34'($signed(item_r.vel_x)); mb = 35'(sw); end
        3'd1: begin ma = 34'($signed(item_r.vel_y)); mb = ONE_Q30 - 35'(cw); end
        3'd2: begin ma = 34'($signed(item_r.vel_y)); mb = 35'(sw); end
        3'd3: begin ma = 34'($signed(item_r.vel_x)); mb = 35'(cw) - ONE_Q30; end
        default: ;
      endcase
    end else if (st_r == B_ROT) begin
      case (step_r)
        3'd0: begin ma = ch; mb = 35'(tx_r); end
        3'd1: begin ma = sh; mb = 35'(ty_r); end
        3'd2: begin ma = sh; mb = 35'(tx_r); end
        3'd3: begin ma = ch; mb = 35'(ty_r); end
        default: ;
      endcase
    end
  end

  // round Q.46 product to Q16.16
  assign pr  = prod_r + (69'sd1 <<< 29);
  assign rnd = pr[68:30];

  // saturate the new position
  always_comb begin
    hx = 1'b0;
    hy = 1'b0;
    sx = accx_r[31:0];
    sy = accy_r[31:0];
    if (accx_r > 40'sd2147483647) begin
      sx = 32'sh7fffffff; hx = 1'b1;
    end else if (accx_r < -40'sd2147483648) begin
      sx = 32'sh80000000; hx = 1'b1;
    end
    if (accy_r > 40'sd2147483647) begin
      sy = 32'sh7fffffff; hy = 1'b1;
    end else if (accy_r < -40'sd2147483648) begin
      sy = 32'sh80000000; hy = 1'b1;
    end
  end

  assign hsum = wrap_angle(35'(head_r) + 35'(item_r.omega));

  // next state
  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          st_nxt = B_CORD;
        end
      end
      B_CORD: begin
        if (!busy_h && !busy_w) st_nxt = item_r.is_small ? B_ROT : B_NUM;
      end
      B_NUM:  if (step_r == 3'd4) st_nxt = B_DIV;
      B_DIV:  if (!busy_dx && !busy_dy) st_nxt = B_ROT;
      B_ROT:  if (step_r == 3'd4) st_nxt = B_OUT;
      B_OUT:  if (!out_valid_r) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      head_r      <= '0;
    end else begin
      st_r <= st_nxt;
      if ((st_r == B_IDLE) && q_valid && q_item.restart) begin
        pos_x_r <= '0;
        pos_y_r <= '0;
        head_r  <= '0;
      end
      if ((st_r == B_OUT) && !out_valid_r) begin
        out_valid_r <= 1'b1;
        pos_x_r     <= sx;
        pos_y_r     <= sy;
        head_r      <= hsum[31:0];
      end else if (pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (st_r != st_nxt) step_r <= '0;
    else                step_r <= step_r + 1'b1;
    if (st_r == B_IDLE) item_r <= q_item;
    unique case (st_r)
      B_CORD: begin
        tx_r <= 34'($signed(item_r.vel_x));
        ty_r <= 34'($signed(item_r.vel_y));
      end
      B_NUM: begin
        if (step_r == 3'd1) nacc_x_r <= 70'(prod_r);
        if (step_r == 3'd2) nacc_x_r <= nacc_x_r + 70'(prod_r);
        if (step_r == 3'd3) nacc_y_r <= 70'(prod_r);
      end
      B_DIV: begin
        tx_r <= qx;
        ty_r <= qy;
      end
      B_ROT: begin
        if (step_r == 3'd1) accx_r <= 40'(pos_x_r) + 40'(rnd);
        if (step_r == 3'd2) accx_r <= accx_r - 40'(rnd);
        if (step_r == 3'd3) accy_r <= 40'(pos_y_r) + 40'(rnd);
        if (step_r == 3'd4) accy_r <= accy_r + 40'(rnd);
      end
      B_OUT: begin
        if (!out_valid_r) begin
          ox_r   <= sx;
          oy_r   <= sy;
          oh_r   <= hsum[31:0];
          osat_r <= hx | hy;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign pose_x    = ox_r;
  assign pose_y    = oy_r;
  assign heading   = oh_r;
  assign saturated = osat_r;

endmodule

FILE: rtl/core/se2_twist_pose_integrator.sv
// Channel   Handshake        Payload
// input     push / full      in_restart, in_omega_in, in_vel_x_in, in_vel_y_in
// result    empty / pop      out_pose_x_out, out_pose_y_out, out_heading_out, out_saturated
// config    cfg_we           cfg_data (small-angle threshold)
//
// A twist that rotates goes from accept to result through the CORDIC and then
// a bit-serial divider; a pure translation skips the divider. The back end runs
// one twist at a time.
// A two-entry queue in front takes new twists while the back end works.
// Reset is synchronous and clears the pose, the queue and the result slot.
// The back end holds its finished pose until pop; full rises when the queue fills.
module se2_twist_pose_integrator #(
  parameter int CORDIC_ITERATIONS = se2_pkg::CORDIC_ITER_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                push,
  output logic                full,
  input  logic                in_restart,
  input  logic signed [31:0]  in_omega_in,
  input  logic signed [31:0]  in_vel_x_in,
  input  logic signed [31:0]  in_vel_y_in,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  out_pose_x_out,
  output logic signed [31:0]  out_pose_y_out,
  output logic signed [31:0]  out_heading_out,
  output logic                out_saturated
);
  import se2_pkg::*;

  logic      q_valid, q_pop, out_valid;
  se2_item_t q_item;

  se2_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push(push), .full(full), .restart(in_restart), .omega(in_omega_in),
    .vel_x(in_vel_x_in), .vel_y(in_vel_y_in),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  se2_back #(.ITER(CORDIC_ITERATIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .pop(pop), .pose_x(out_pose_x_out),
    .pose_y(out_pose_y_out), .heading(out_heading_out), .saturated(out_saturated)
  );

  assign empty = !out_valid;

endmodule

FILE: rtl/core/se2_checker.sv
module se2_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic signed [31:0]  out_pose_x_out,
  input logic signed [31:0]  out_heading_out
);

  // reset leaves no result and room in the queue
  a_reset: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("not empty/full after reset");

  // one result slot: a taken result is never followed at once by another
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop) |=> empty)
    else $error("result appeared right after pop");

  // waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pose_x_out)))
    else $error("result changed while waiting");

  // heading stays wrapped
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_heading_out >= -32'sd843314857 && out_heading_out < 32'sd843314857))
    else $error("heading out of range");

endmodule

bind se2_twist_pose_integrator se2_checker u_se2_checker (
  .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
  .out_pose_x_out(out_pose_x_out), .out_heading_out(out_heading_out)
);
